// ===== hdl/iae_pkg.sv =====
// Shared types, operation codes and helpers for the integer ALU execute core.
`timescale 1ns / 1ps
`default_nettype none
package iae_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned RegIdxWidth = 5;
  localparam int unsigned TagWidth = 5;
  localparam int unsigned LitWidth = 8;
  localparam int unsigned ShiftWidth = 5;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [RegIdxWidth-1:0] reg_idx_t;
  typedef logic [TagWidth-1:0] tag_t;

  localparam tag_t OP_ADD = 5'd0;
  localparam tag_t OP_SUB = 5'd1;
  localparam tag_t OP_SLL = 5'd2;
  localparam tag_t OP_SRL = 5'd3;
  localparam tag_t OP_SRA = 5'd4;
  localparam tag_t OP_AND = 5'd5;
  localparam tag_t OP_OR = 5'd6;
  localparam tag_t OP_XOR = 5'd7;
  localparam tag_t OP_S4ADD = 5'd8;
  localparam tag_t OP_CMPULT = 5'd22;
  localparam tag_t OP_CMPULE = 5'd23;
  localparam tag_t OP_CMPNE = 5'd24;
  localparam tag_t OP_CMPEQ = 5'd25;
  localparam tag_t OP_CMPLT = 5'd26;
  localparam tag_t OP_CMPLE = 5'd27;
  localparam tag_t OP_FCMPLT = 5'd30;
  localparam tag_t OP_FCMPLE = 5'd31;

  // Stage 1 to stage 2: decoded fields and the formed second operand.
  typedef struct packed {
    logic     valid;
    reg_idx_t dest;
    tag_t     tag;
    word_t    a;
    word_t    b;
    word_t    t;
  } dec_stage_t;

  // Stage 2 to stage 3: outputs of the parallel units.
  typedef struct packed {
    logic     valid;
    reg_idx_t dest;
    tag_t     tag;
    word_t    a;
    word_t    t;
    word_t    sum;
    word_t    diff;
    word_t    scaled;
    word_t    shl;
    word_t    shr;
    word_t    sra;
    logic     eq;
    logic     ult;
    logic     slt;
    logic     flt;
    logic     fle;
  } exe_stage_t;

endpackage
`default_nettype wire

// ===== hdl/iae_decode.sv =====
// First pipeline stage: field decode and second operand formation.
`timescale 1ns / 1ps
`default_nettype none
module iae_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire iae_pkg::word_t      instruction,
  input  wire iae_pkg::word_t      value_a,
  input  wire iae_pkg::word_t      value_b,
  output iae_pkg::dec_stage_t      stage
);

  logic [iae_pkg::LitWidth-1:0] lit;
  iae_pkg::word_t               t_next;

  assign lit = instruction[12:5];
  assign t_next = value_b + {{(iae_pkg::WordWidth-iae_pkg::LitWidth){lit[iae_pkg::LitWidth-1]}},
                             lit};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage.dest <= instruction[27:23];
    stage.tag  <= instruction[4:0];
    stage.a    <= value_a;
    stage.b    <= value_b;
    stage.t    <= t_next;
  end

endmodule
`default_nettype wire

// ===== hdl/iae_execute.sv =====
// Second pipeline stage: adders, shifters and comparators in parallel.
`timescale 1ns / 1ps
`default_nettype none
module iae_execute (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire iae_pkg::dec_stage_t in_stage,
  output iae_pkg::exe_stage_t      out_stage
);

  logic [iae_pkg::ShiftWidth-1:0] sh;
  logic                           sa;
  logic                           sb;
  logic [iae_pkg::WordWidth-2:0]  ma;
  logic [iae_pkg::WordWidth-2:0]  mb;
  logic                           nan_a;
  logic                           nan_b;
  logic                           both_zero;
  logic                           key_lt;
  logic                           key_eq;

  assign sh = in_stage.t[iae_pkg::ShiftWidth-1:0];
  assign sa = in_stage.a[iae_pkg::WordWidth-1];
  assign sb = in_stage.b[iae_pkg::WordWidth-1];
  assign ma = in_stage.a[iae_pkg::WordWidth-2:0];
  assign mb = in_stage.b[iae_pkg::WordWidth-2:0];
  assign nan_a = (in_stage.a[30:23] == 8'hff) && (in_stage.a[22:0] != '0);
  assign nan_b = (in_stage.b[30:23] == 8'hff) && (in_stage.b[22:0] != '0);
  assign both_zero = (ma == '0) && (mb == '0);

  // Sign-magnitude ordering; the two zeros are one key.
  always_comb begin
    key_eq = both_zero || ((sa == sb) && (ma == mb));
    case ({sa, sb})
      2'b00:   key_lt = ma < mb;
      2'b11:   key_lt = mb < ma;
      2'b10:   key_lt = !both_zero;
      default: key_lt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else begin
      out_stage.valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage.dest   <= in_stage.dest;
    out_stage.tag    <= in_stage.tag;
    out_stage.a      <= in_stage.a;
    out_stage.t      <= in_stage.t;
    out_stage.sum    <= in_stage.a + in_stage.t;
    out_stage.diff   <= in_stage.a - in_stage.t;
    out_stage.scaled <= in_stage.a + {in_stage.t[iae_pkg::WordWidth-3:0], 2'b00};
    out_stage.shl    <= in_stage.a << sh;
    out_stage.shr    <= in_stage.a >> sh;
    out_stage.sra    <= iae_pkg::word_t'($signed(in_stage.a) >>> sh);
    out_stage.eq     <= in_stage.a == in_stage.t;
    out_stage.ult    <= in_stage.a < in_stage.t;
    out_stage.slt    <= $signed(in_stage.a) < $signed(in_stage.t);
    out_stage.flt    <= !nan_a && !nan_b && key_lt;
    out_stage.fle    <= !nan_a && !nan_b && (key_lt || key_eq);
  end

endmodule
`default_nettype wire

// ===== hdl/integer_alu_execute_core.sv =====
// Top level of the integer ALU execute core: three-stage pipeline with result select.
// An accepted transfer passes the decode, execute and output registers in turn before its
// result shows with done high.
// Throughput: one instruction per cycle; busy is never raised and start may stay high.
// Stages: decode and operand add, parallel units, result select and output register.
// Reset: synchronous rst clears the stage valid bits, so done is low after reset.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_execute_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire iae_pkg::word_t             instruction,
  input  wire iae_pkg::word_t             value_a,
  input  wire iae_pkg::word_t             value_b,
  output logic                            done,
  output iae_pkg::reg_idx_t               dest_index,
  output iae_pkg::word_t                  result,
  output logic                            decode_error
);

  iae_pkg::dec_stage_t dec_stage;
  iae_pkg::exe_stage_t exe_stage;
  iae_pkg::word_t      result_next;
  logic                error_next;

  assign busy = 1'b0;

  iae_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (start && !busy),
    .instruction(instruction),
    .value_a    (value_a),
    .value_b    (value_b),
    .stage      (dec_stage)
  );

  iae_execute u_execute (
    .clk      (clk),
    .rst      (rst),
    .in_stage (dec_stage),
    .out_stage(exe_stage)
  );

  always_comb begin
    result_next = '0;
    error_next  = 1'b0;
    unique case (exe_stage.tag)
      iae_pkg::OP_ADD:    result_next = exe_stage.sum;
      iae_pkg::OP_SUB:    result_next = exe_stage.diff;
      iae_pkg::OP_SLL:    result_next = exe_stage.shl;
      iae_pkg::OP_SRL:    result_next = exe_stage.shr;
      iae_pkg::OP_SRA:    result_next = exe_stage.sra;
      iae_pkg::OP_AND:    result_next = exe_stage.a & exe_stage.t;
      iae_pkg::OP_OR:     result_next = exe_stage.a | exe_stage.t;
      iae_pkg::OP_XOR:    result_next = exe_stage.a ^ exe_stage.t;
      iae_pkg::OP_S4ADD:  result_next = exe_stage.scaled;
      iae_pkg::OP_CMPULT: result_next = iae_pkg::word_t'(exe_stage.ult);
      iae_pkg::OP_CMPULE: result_next = iae_pkg::word_t'(exe_stage.ult || exe_stage.eq);
      iae_pkg::OP_CMPNE:  result_next = iae_pkg::word_t'(!exe_stage.eq);
      iae_pkg::OP_CMPEQ:  result_next = iae_pkg::word_t'(exe_stage.eq);
      iae_pkg::OP_CMPLT:  result_next = iae_pkg::word_t'(exe_stage.slt);
      iae_pkg::OP_CMPLE:  result_next = iae_pkg::word_t'(exe_stage.slt || exe_stage.eq);
      iae_pkg::OP_FCMPLT: result_next = iae_pkg::word_t'(exe_stage.flt);
      iae_pkg::OP_FCMPLE: result_next = iae_pkg::word_t'(exe_stage.fle);
      default:            error_next  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exe_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    dest_index   <= exe_stage.dest;
    result       <= result_next;
    decode_error <= error_next;
  end

endmodule
`default_nettype wire

// ===== hdl/iae_checker.sv =====
// Port-level checker for the integer ALU execute core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module iae_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire iae_pkg::word_t    instruction,
  input wire logic              done,
  input wire iae_pkg::reg_idx_t dest_index,
  input wire iae_pkg::word_t    result,
  input wire logic              decode_error
);

  // Every accepted transfer comes out with done high.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted instruction produced no result");

  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result strobe without a matching accepted instruction");

  a_dest_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> (dest_index == $past(instruction[27:23], 3)))
    else $error("destination index does not match its instruction");

  a_error_zero_result: assert property (@(posedge clk) disable iff (rst)
    (done && decode_error) |-> (result == '0))
    else $error("decode error with a nonzero result");

endmodule

bind integer_alu_execute_core iae_checker u_iae_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .instruction (instruction),
  .done        (done),
  .dest_index  (dest_index),
  .result      (result),
  .decode_error(decode_error)
);
`default_nettype wire

// ===== sim/integer_alu_execute_core_tb.sv =====
// Self-checking testbench for the integer ALU execute core: directed and random instructions.
`timescale 1ns / 1ps
module integer_alu_execute_core_tb;

  // Tags with no operation behind them.
  localparam iae_pkg::tag_t TagGapFirst = 5'd9;
  localparam iae_pkg::tag_t TagGapLast = 5'd21;
  localparam iae_pkg::tag_t TagSpareLow = 5'd28;
  localparam iae_pkg::tag_t TagSpareHigh = 5'd29;

  localparam iae_pkg::word_t FpPosZero = 32'h0000_0000;
  localparam iae_pkg::word_t FpNegZero = 32'h8000_0000;
  localparam iae_pkg::word_t FpPosInf = 32'h7f80_0000;
  localparam iae_pkg::word_t FpNegInf = 32'hff80_0000;
  localparam iae_pkg::word_t FpQuietNan = 32'h7fc0_0000;
  localparam iae_pkg::word_t FpNegNan = 32'hffc0_0001;
  localparam iae_pkg::word_t FpOne = 32'h3f80_0000;
  localparam iae_pkg::word_t FpMinusOne = 32'hbf80_0000;
  localparam iae_pkg::word_t FpMinusTwo = 32'hc000_0000;
  localparam iae_pkg::word_t FpDenorm = 32'h0000_0001;

  typedef struct {
    iae_pkg::reg_idx_t dest;
    iae_pkg::word_t    value;
    logic              err;
  } alu_out_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  iae_pkg::word_t    instruction;
  iae_pkg::word_t    value_a;
  iae_pkg::word_t    value_b;
  logic              done;
  iae_pkg::reg_idx_t dest_index;
  iae_pkg::word_t    result;
  logic              decode_error;

  alu_out_t pending_results[$];
  int       error_count = 0;
  bit       allow_gaps = 1'b1;

  iae_pkg::tag_t defined_ops[17] = '{
    iae_pkg::OP_ADD, iae_pkg::OP_SUB, iae_pkg::OP_SLL, iae_pkg::OP_SRL, iae_pkg::OP_SRA,
    iae_pkg::OP_AND, iae_pkg::OP_OR, iae_pkg::OP_XOR, iae_pkg::OP_S4ADD,
    iae_pkg::OP_CMPULT, iae_pkg::OP_CMPULE, iae_pkg::OP_CMPNE, iae_pkg::OP_CMPEQ,
    iae_pkg::OP_CMPLT, iae_pkg::OP_CMPLE, iae_pkg::OP_FCMPLT, iae_pkg::OP_FCMPLE};
  iae_pkg::word_t fp_values[10] = '{FpPosZero, FpNegZero, FpPosInf, FpNegInf, FpQuietNan,
                                    FpNegNan, FpOne, FpMinusOne, FpMinusTwo, FpDenorm};

  integer_alu_execute_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .instruction  (instruction),
    .value_a      (value_a),
    .value_b      (value_b),
    .done         (done),
    .dest_index   (dest_index),
    .result       (result),
    .decode_error (decode_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("integer_alu_execute_core_tb NOT OK");
    $finish;
  end

  function automatic bit fp_nan(iae_pkg::word_t x);
    return x[30:23] == 8'hff && x[22:0] != 23'd0;
  endfunction

  // Sign-magnitude to a plain ordered number; both zeros land on 0.
  function automatic longint fp_order(iae_pkg::word_t x);
    longint mag;
    mag = longint'(x[30:0]);
    return x[31] ? -mag : mag;
  endfunction

  function automatic alu_out_t alu_predict(iae_pkg::word_t inst, iae_pkg::word_t a,
                                           iae_pkg::word_t b);
    alu_out_t       r;
    iae_pkg::tag_t  tag;
    iae_pkg::word_t t;
    logic [4:0]     sh;
    tag = inst[4:0];
    t = b + {{24{inst[12]}}, inst[12:5]};
    sh = t[4:0];
    r.dest = inst[27:23];
    r.err = 1'b0;
    r.value = '0;
    case (tag)
      iae_pkg::OP_ADD:    r.value = a + t;
      iae_pkg::OP_SUB:    r.value = a - t;
      iae_pkg::OP_SLL:    r.value = a << sh;
      iae_pkg::OP_SRL:    r.value = a >> sh;
      iae_pkg::OP_SRA:    r.value = iae_pkg::word_t'($signed(a) >>> sh);
      iae_pkg::OP_AND:    r.value = a & t;
      iae_pkg::OP_OR:     r.value = a | t;
      iae_pkg::OP_XOR:    r.value = a ^ t;
      iae_pkg::OP_S4ADD:  r.value = a + (t << 2);
      iae_pkg::OP_CMPULT: r.value = iae_pkg::word_t'(a < t);
      iae_pkg::OP_CMPULE: r.value = iae_pkg::word_t'(a <= t);
      iae_pkg::OP_CMPNE:  r.value = iae_pkg::word_t'(a != t);
      iae_pkg::OP_CMPEQ:  r.value = iae_pkg::word_t'(a == t);
      iae_pkg::OP_CMPLT:  r.value = iae_pkg::word_t'($signed(a) < $signed(t));
      iae_pkg::OP_CMPLE:  r.value = iae_pkg::word_t'($signed(a) <= $signed(t));
      iae_pkg::OP_FCMPLT:
        r.value = iae_pkg::word_t'(!fp_nan(a) && !fp_nan(b) && fp_order(a) < fp_order(b));
      iae_pkg::OP_FCMPLE:
        r.value = iae_pkg::word_t'(!fp_nan(a) && !fp_nan(b) && fp_order(a) <= fp_order(b));
      default:            r.err = 1'b1;
    endcase
    return r;
  endfunction

  // Ignored bits come from the spare argument.
  function automatic iae_pkg::word_t make_inst(iae_pkg::reg_idx_t dest, logic [7:0] lit,
                                               iae_pkg::tag_t tag, iae_pkg::word_t spare);
    iae_pkg::word_t w;
    w = spare;
    w[27:23] = dest;
    w[12:5] = lit;
    w[4:0] = tag;
    return w;
  endfunction

  function automatic iae_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return fp_values[$urandom_range(0, 9)];
      5: return iae_pkg::word_t'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input iae_pkg::word_t inst, input iae_pkg::word_t a,
                         input iae_pkg::word_t b);
    start <= 1'b1;
    instruction <= inst;
    value_a <= a;
    value_b <= b;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(alu_predict(inst, a, b));
    if (allow_gaps && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    alu_out_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual dest %0d result %h err %b",
                 $time, dest_index, result, decode_error);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (dest_index !== want.dest) begin
          $display("%0t: dest_index expected %0d actual %0d", $time, want.dest, dest_index);
          error_count++;
        end
        if (result !== want.value) begin
          $display("%0t: result expected %h actual %h", $time, want.value, result);
          error_count++;
        end
        if (decode_error !== want.err) begin
          $display("%0t: decode_error expected %b actual %b", $time, want.err, decode_error);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    // Literal sign extension and wraparound at both ends.
    send_op(make_inst(5'd0, 8'd1, iae_pkg::OP_ADD, '0), 32'hffff_ffff, 32'h0000_0000);
    send_op(make_inst(5'd31, 8'h80, iae_pkg::OP_SUB, '1), 32'h0000_0000, 32'h0000_0000);
    // Shift counts above 31 keep only the low five bits.
    send_op(make_inst(5'd1, 8'd1, iae_pkg::OP_SLL, '0), 32'h8000_0001, 32'd32);
    send_op(make_inst(5'd2, 8'd0, iae_pkg::OP_SRL, '0), 32'h8000_0000, 32'd31);
    send_op(make_inst(5'd3, 8'hff, iae_pkg::OP_SRA, '0), 32'h8000_0000, 32'd0);
    send_op(make_inst(5'd4, 8'h7f, iae_pkg::OP_AND, '1), 32'hffff_ffff, 32'hffff_ff80);
    send_op(make_inst(5'd5, 8'h7f, iae_pkg::OP_OR, '0), 32'h1234_5678, 32'h0000_0000);
    send_op(make_inst(5'd6, 8'h80, iae_pkg::OP_XOR, '0), 32'hffff_ffff, 32'h7fff_ffff);
    send_op(make_inst(5'd7, 8'd0, iae_pkg::OP_S4ADD, '0), 32'h0000_0001, 32'h4000_0000);
    send_op(make_inst(5'd8, 8'hff, iae_pkg::OP_CMPULT, '0), 32'h0000_0000, 32'h0000_0000);
    send_op(make_inst(5'd9, 8'd1, iae_pkg::OP_CMPULE, '0), 32'h0000_0010, 32'h0000_000f);
    send_op(make_inst(5'd10, 8'd0, iae_pkg::OP_CMPNE, '0), 32'hdead_beef, 32'hdead_beef);
    send_op(make_inst(5'd11, 8'hfe, iae_pkg::OP_CMPEQ, '0), 32'h0000_0000, 32'h0000_0002);
    send_op(make_inst(5'd12, 8'd0, iae_pkg::OP_CMPLT, '0), 32'h8000_0000, 32'h7fff_ffff);
    send_op(make_inst(5'd13, 8'd0, iae_pkg::OP_CMPLE, '0), 32'h8000_0000, 32'h8000_0000);
    // Float compares: signed zeros, NaN on either side, infinities, negatives.
    send_op(make_inst(5'd14, 8'd0, iae_pkg::OP_FCMPLT, '0), FpNegZero, FpPosZero);
    send_op(make_inst(5'd15, 8'd0, iae_pkg::OP_FCMPLE, '0), FpNegZero, FpPosZero);
    send_op(make_inst(5'd16, 8'd0, iae_pkg::OP_FCMPLT, '0), FpQuietNan, FpOne);
    send_op(make_inst(5'd17, 8'd0, iae_pkg::OP_FCMPLE, '0), FpMinusOne, FpNegNan);
    send_op(make_inst(5'd18, 8'd0, iae_pkg::OP_FCMPLT, '0), FpNegInf, FpPosInf);
    send_op(make_inst(5'd19, 8'd0, iae_pkg::OP_FCMPLE, '0), FpMinusTwo, FpMinusOne);
    // Undefined tags still carry the destination through.
    send_op(make_inst(5'd31, 8'hff, TagGapFirst, '1), 32'hffff_ffff, 32'hffff_ffff);
    send_op(make_inst(5'd20, 8'd5, TagGapLast, '0), 32'h1111_1111, 32'h2222_2222);
    send_op(make_inst(5'd21, 8'd7, TagSpareLow, '0), 32'h3333_3333, 32'h4444_4444);
    send_op(make_inst(5'd22, 8'd9, TagSpareHigh, '1), 32'h5555_5555, 32'h6666_6666);
  endtask

  task automatic test_random();
    iae_pkg::word_t inst;
    iae_pkg::word_t a;
    iae_pkg::word_t b;
    iae_pkg::tag_t  tag;
    for (int i = 0; i < 2000; i++) begin
      allow_gaps = !(i >= 700 && i < 1100);
      if ($urandom_range(0, 99) < 85) tag = defined_ops[$urandom_range(0, 16)];
      else tag = iae_pkg::tag_t'($urandom);
      inst = $urandom;
      inst[4:0] = tag;
      a = pick_word();
      b = pick_word();
      // Now and then make the second operand land exactly on the first.
      if ($urandom_range(0, 5) == 0)
        b = a - {{24{inst[12]}}, inst[12:5]};
      send_op(inst, a, b);
    end
  endtask

  task automatic finish_run();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, first expected dest %0d result %h err %b",
               $time, pending_results.size(), pending_results[0].dest,
               pending_results[0].value, pending_results[0].err);
      error_count++;
    end
    if (error_count == 0) begin
      $display("integer_alu_execute_core_tb OK");
    end else begin
      $display("integer_alu_execute_core_tb NOT OK");
    end
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    instruction = '0;
    value_a = '0;
    value_b = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    finish_run();
  end

endmodule

// ===== sim.f =====
hdl/iae_pkg.sv
hdl/iae_decode.sv
hdl/iae_execute.sv
hdl/integer_alu_execute_core.sv
hdl/iae_checker.sv
sim/integer_alu_execute_core_tb.sv
